/* rtl/plt_pkg.sv */
// Shared constants, codes and control types for the positional list table.
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CMD_W    = 3;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;
   localparam int FPOS_W   = 4;
   localparam int CNT_W    = 5;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FIND_FIRST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND_ALL   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_SETUP_INS,
      OP_SETUP_REM,
      OP_SETUP_SCAN,
      OP_SHIFT_UP,
      OP_SHIFT_DN,
      OP_SCAN_STEP,
      OP_PUT
   } op_type;

   typedef enum logic [1:0] {
      SEL_VAL,
      SEL_INS,
      SEL_GET,
      SEL_SCAN
   } sel_type;

   typedef struct packed {
      logic                load;
      op_type              op;
      logic                fill_dec;
      logic                count_inc;
      logic                emit;
      sel_type             sel;
      logic [STATUS_W-1:0] status;
      logic                last;
   } ctrl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             empty;
      logic             full;
      logic             pos_gt_fill;
      logic             pos_ge_fill;
      logic             rem_zero;
      logic             pend;
      logic             hit;
      logic             count_zero;
      logic             out_free;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/plt_req_if.sv */
// Request channel interface: valid, ready and one command word.
`timescale 1ns / 1ps
`default_nettype none

interface plt_req_if
   import plt_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [VAL_W-1:0] item_value;
   logic [POS_W-1:0]        item_position;

   modport source (output valid, cmd, item_value, item_position, input ready);
   modport sink   (input valid, cmd, item_value, item_position, output ready);
endinterface

`default_nettype wire

/* rtl/plt_rsp_if.sv */
// Response channel interface: valid, ready and one result word.
`timescale 1ns / 1ps
`default_nettype none

interface plt_rsp_if
   import plt_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [FPOS_W-1:0]       found_position;
   logic signed [VAL_W-1:0] entry_value;
   logic [CNT_W-1:0]        match_count;
   logic                    last_of_run;

   modport source (output valid, status, found_position, entry_value, match_count,
                   last_of_run, input ready);
   modport sink   (input valid, status, found_position, entry_value, match_count,
                   last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/plt_datapath.sv */
// Datapath: entry memory, fill count, shift and scan pointers, result register.
`timescale 1ns / 1ps
`default_nettype none

module plt_datapath
   import plt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctrl_type                ctrl,
   output stat_type                     stat,
   input  wire logic [CMD_W-1:0]        req_cmd,
   input  wire logic signed [VAL_W-1:0] req_item_value,
   input  wire logic [POS_W-1:0]        req_item_position,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [FPOS_W-1:0]            rsp_found_position,
   output logic signed [VAL_W-1:0]      rsp_entry_value,
   output logic [CNT_W-1:0]             rsp_match_count,
   output logic                         rsp_last_of_run
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic signed [VAL_W-1:0] mem [DEPTH];

   logic [CMD_W-1:0]        cmd_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [CW-1:0]           fill_ff, fill_in;
   logic [CW-1:0]           ptr_ff, ptr_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic                    pend_ff, pend_in;
   logic signed [VAL_W-1:0] rdata_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    rd_en, wr_en;
   logic [AW-1:0]           rd_addr, wr_addr, pos_idx;
   logic signed [VAL_W-1:0] wr_data;
   logic [PW-1:0]           pos_w, fill_w;

   assign pos_w   = PW'(pos_ff);
   assign fill_w  = PW'(fill_ff);
   assign pos_idx = AW'(pos_ff);

   always_comb begin
      fill_in   = fill_ff;
      ptr_in    = ptr_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      pend_in   = pend_ff;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = wr_ptr_ff;
      wr_data   = rdata_ff;
      case (ctrl.op)
         OP_SETUP_INS: begin
            ptr_in  = fill_ff - CW'(1);
            rem_in  = CW'(fill_w - pos_w);
            pend_in = 1'b0;
         end
         OP_SETUP_REM: begin
            rd_en   = 1'b1;
            rd_addr = pos_idx;
            ptr_in  = CW'(pos_w + PW'(1));
            rem_in  = CW'(fill_w - pos_w - PW'(1));
            pend_in = 1'b0;
         end
         OP_SETUP_SCAN: begin
            ptr_in  = '0;
            rem_in  = fill_ff;
            pend_in = 1'b0;
         end
         OP_SHIFT_UP, OP_SHIFT_DN, OP_SCAN_STEP: begin
            // The word read last cycle is written one place over while the
            // next one is read, so a shift moves one entry per cycle.
            wr_en = pend_ff && (ctrl.op != OP_SCAN_STEP);
            if (rem_ff != '0) begin
               rd_en   = 1'b1;
               rem_in  = rem_ff - CW'(1);
               pend_in = 1'b1;
               case (ctrl.op)
                  OP_SHIFT_UP: begin
                     ptr_in    = ptr_ff - CW'(1);
                     wr_ptr_in = AW'(ptr_ff + CW'(1));
                  end
                  OP_SHIFT_DN: begin
                     ptr_in    = ptr_ff + CW'(1);
                     wr_ptr_in = AW'(ptr_ff - CW'(1));
                  end
                  default: begin
                     ptr_in    = ptr_ff + CW'(1);
                     wr_ptr_in = ptr_ff[AW-1:0];
                  end
               endcase
            end else begin
               pend_in = 1'b0;
            end
         end
         OP_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_idx;
            wr_data = val_ff;
            fill_in = fill_ff + CW'(1);
         end
         default: begin
         end
      endcase
      if (ctrl.fill_dec) begin
         fill_in = fill_ff - CW'(1);
      end
      if (ctrl.count_inc) begin
         count_in = count_ff + CW'(1);
      end
      if (ctrl.load) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_cmd;
         val_ff <= req_item_value;
         pos_ff <= req_item_position;
      end
      ptr_ff    <= ptr_in;
      rem_ff    <= rem_in;
      count_ff  <= count_in;
      wr_ptr_ff <= wr_ptr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = ctrl.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_status      <= ctrl.status;
         rsp_last_of_run <= ctrl.last;
         case (ctrl.sel)
            SEL_INS: begin
               rsp_found_position <= FPOS_W'(pos_ff);
               rsp_entry_value    <= val_ff;
               rsp_match_count    <= '0;
            end
            SEL_GET: begin
               rsp_found_position <= FPOS_W'(pos_ff);
               rsp_entry_value    <= rdata_ff;
               rsp_match_count    <= '0;
            end
            SEL_SCAN: begin
               rsp_found_position <= FPOS_W'(wr_ptr_ff);
               rsp_entry_value    <= rdata_ff;
               rsp_match_count    <= '0;
            end
            default: begin
               rsp_found_position <= '0;
               rsp_entry_value    <= val_ff;
               rsp_match_count    <= CNT_W'(count_ff);
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.cmd         = cmd_ff;
      stat.empty       = (fill_ff == '0);
      stat.full        = (fill_ff == CW'(DEPTH));
      stat.pos_gt_fill = (pos_w > fill_w);
      stat.pos_ge_fill = (pos_w >= fill_w);
      stat.rem_zero    = (rem_ff == '0);
      stat.pend        = pend_ff;
      stat.hit         = (rdata_ff == val_ff);
      stat.count_zero  = (count_ff == '0);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

/* rtl/plt_ctrl.sv */
// Controller: command decode, error checks and sequencing of shifts and scans.
`timescale 1ns / 1ps
`default_nettype none

module plt_ctrl
   import plt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output ctrl_type      ctrl
);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_DECODE    = 8'b0000_0010,
      S_INS_SHIFT = 8'b0000_0100,
      S_INS_PUT   = 8'b0000_1000,
      S_GET       = 8'b0001_0000,
      S_REM_SHIFT = 8'b0010_0000,
      S_SCAN      = 8'b0100_0000,
      S_SCAN_END  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic is_insert, is_remove, is_ffirst, is_fall, is_read, is_dump, need_emit;

   assign is_insert = (stat.cmd == CMD_INSERT);
   assign is_remove = (stat.cmd == CMD_REMOVE);
   assign is_ffirst = (stat.cmd == CMD_FIND_FIRST);
   assign is_fall   = (stat.cmd == CMD_FIND_ALL);
   assign is_read   = (stat.cmd == CMD_READ);
   assign is_dump   = (stat.cmd == CMD_DUMP);
   assign need_emit = stat.pend && (is_dump || stat.hit);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      ctrl.load      = 1'b0;
      ctrl.op        = OP_NONE;
      ctrl.fill_dec  = 1'b0;
      ctrl.count_inc = 1'b0;
      ctrl.emit      = 1'b0;
      ctrl.sel       = SEL_VAL;
      ctrl.status    = ST_OK;
      ctrl.last      = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            // Errors leave a single word; wait here for the output slot.
            if (is_insert) begin
               if (stat.full || stat.pos_gt_fill) begin
                  ctrl.status = stat.full ? ST_FULL : ST_BADPOS;
                  if (stat.out_free) begin
                     ctrl.emit = 1'b1;
                     state_in  = S_IDLE;
                  end
               end else begin
                  ctrl.op  = OP_SETUP_INS;
                  state_in = S_INS_SHIFT;
               end
            end else if (is_remove || is_read) begin
               if (stat.empty || stat.pos_ge_fill) begin
                  ctrl.status = stat.empty ? ST_EMPTY : ST_BADPOS;
                  if (stat.out_free) begin
                     ctrl.emit = 1'b1;
                     state_in  = S_IDLE;
                  end
               end else begin
                  ctrl.op  = OP_SETUP_REM;
                  state_in = S_GET;
               end
            end else if (is_ffirst || is_fall || is_dump) begin
               if (stat.empty) begin
                  ctrl.status = ST_EMPTY;
                  if (stat.out_free) begin
                     ctrl.emit = 1'b1;
                     state_in  = S_IDLE;
                  end
               end else begin
                  ctrl.op  = OP_SETUP_SCAN;
                  state_in = S_SCAN;
               end
            end else begin
               // Unused command codes leave no word and change nothing.
               state_in = S_IDLE;
            end
         end
         S_INS_SHIFT: begin
            ctrl.op = OP_SHIFT_UP;
            if (stat.rem_zero) begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            if (stat.out_free) begin
               ctrl.op   = OP_PUT;
               ctrl.emit = 1'b1;
               ctrl.sel  = SEL_INS;
               state_in  = S_IDLE;
            end
         end
         S_GET: begin
            if (stat.out_free) begin
               ctrl.emit = 1'b1;
               ctrl.sel  = SEL_GET;
               state_in  = is_remove ? S_REM_SHIFT : S_IDLE;
            end
         end
         S_REM_SHIFT: begin
            ctrl.op = OP_SHIFT_DN;
            if (stat.rem_zero) begin
               ctrl.fill_dec = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            // The read runs one entry ahead of the compare; a full output slot freezes
            // both when a word is due.
            if (!(need_emit && !stat.out_free)) begin
               ctrl.op = OP_SCAN_STEP;
               if (need_emit) begin
                  ctrl.emit = 1'b1;
                  ctrl.sel  = SEL_SCAN;
                  ctrl.last = is_ffirst || (is_dump && stat.rem_zero);
               end
               if (is_fall && stat.pend && stat.hit) begin
                  ctrl.count_inc = 1'b1;
               end
               if (is_ffirst && stat.pend && stat.hit) begin
                  state_in = S_IDLE;
               end else if (stat.pend && stat.rem_zero) begin
                  state_in = is_dump ? S_IDLE : S_SCAN_END;
               end
            end
         end
         S_SCAN_END: begin
            ctrl.status = (is_fall && !stat.count_zero) ? ST_OK : ST_NOTFOUND;
            if (stat.out_free) begin
               ctrl.emit = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/positional_list_table.sv */
// Top level: bounded ordered list with insert, remove, find, read and dump.
// Each command is accepted in the idle state, then decoded; errors and unused codes end there,
// insert shifts the tail up and then puts the value, read fetches the entry, remove fetches it
// and shifts the tail down; scans read one entry per cycle until a word finds the slot full.
// One command at a time; a result word is valid the cycle after its step, and a held slot stalls it.
// Reset clears the fill count, the controller and the output valid, but not the entries.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_table
   import plt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   plt_req_if.sink  req,
   plt_rsp_if.source rsp
);

   ctrl_type ctrl;
   stat_type stat;

   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   plt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .stat               (stat),
      .req_cmd            (req.cmd),
      .req_item_value     (req.item_value),
      .req_item_position  (req.item_position),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_status         (rsp.status),
      .rsp_found_position (rsp.found_position),
      .rsp_entry_value    (rsp.entry_value),
      .rsp_match_count    (rsp.match_count),
      .rsp_last_of_run    (rsp.last_of_run)
   );

endmodule

`default_nettype wire

/* test/positional_list_table_tb.sv */
// Self-checking testbench for the positional list table: directed, capacity, stall and random tests.
`timescale 1ns / 1ps

module positional_list_table_tb;
   import plt_pkg::*;

   localparam int LIST_DEPTH     = DEPTH_DEFAULT;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 2 * LIST_DEPTH + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRINT_LIMIT    = 40;

   // Codes 6 and 7 are not commands; the block must swallow them silently.
   localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

   localparam logic signed [VAL_W-1:0] VAL_MIN   = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_TWIN  = 32'sh1234_5678;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [FPOS_W-1:0]       found_position;
      logic signed [VAL_W-1:0] entry_value;
      logic [CNT_W-1:0]        match_count;
      logic                    last_of_run;
   } list_result_type;

   logic clock = 1'b0;
   logic reset;

   plt_req_if req_ch ();
   plt_rsp_if rsp_ch ();

   positional_list_table #(.DEPTH(LIST_DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the list, updated as each command word is accepted.
   logic signed [VAL_W-1:0] model_entries [LIST_DEPTH];
   int                      model_fill;
   list_result_type         expected_words [$];

   int send_idle_pct;
   int stall_pct;
   bit hold_start;
   int hold_left;
   int errors;
   int commands_sent;
   int words_seen;
   int phases_run;
   int quiet_cycles;

   logic signed [VAL_W-1:0] value_pool [4] = '{32'sd7, -32'sd7, VAL_MAX, VAL_MIN};

   task automatic report_mismatch(input string what);
      if (errors < PRINT_LIMIT)
         $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
   endtask

   task automatic push_result(input logic [STATUS_W-1:0] status, input int pos,
                              input logic signed [VAL_W-1:0] val, input int cnt,
                              input logic last);
      list_result_type r;
      r.status         = status;
      r.found_position = FPOS_W'(pos);
      r.entry_value    = val;
      r.match_count    = CNT_W'(cnt);
      r.last_of_run    = last;
      expected_words.push_back(r);
   endtask

   task automatic predict_list_command(input logic [CMD_W-1:0] cmd,
                                       input logic signed [VAL_W-1:0] val,
                                       input logic [POS_W-1:0] pos);
      int i;
      int hits;
      int p;
      p = int'(pos);
      hits = 0;
      case (cmd)
         CMD_INSERT: begin
            if (model_fill >= LIST_DEPTH) begin
               push_result(ST_FULL, 0, val, 0, 1'b1);
            end else if (p > model_fill) begin
               push_result(ST_BADPOS, 0, val, 0, 1'b1);
            end else begin
               for (i = model_fill; i > p; i--)
                  model_entries[i] = model_entries[i-1];
               model_entries[p] = val;
               model_fill++;
               push_result(ST_OK, p, val, 0, 1'b1);
            end
         end
         CMD_REMOVE, CMD_READ: begin
            if (model_fill == 0) begin
               push_result(ST_EMPTY, 0, val, 0, 1'b1);
            end else if (p >= model_fill) begin
               push_result(ST_BADPOS, 0, val, 0, 1'b1);
            end else begin
               push_result(ST_OK, p, model_entries[p], 0, 1'b1);
               if (cmd == CMD_REMOVE) begin
                  for (i = p; i + 1 < model_fill; i++)
                     model_entries[i] = model_entries[i+1];
                  model_fill--;
               end
            end
         end
         CMD_FIND_FIRST: begin
            if (model_fill == 0) begin
               push_result(ST_EMPTY, 0, val, 0, 1'b1);
            end else begin
               for (i = 0; i < model_fill && hits == 0; i++)
                  if (model_entries[i] == val) begin
                     push_result(ST_OK, i, val, 0, 1'b1);
                     hits++;
                  end
               if (hits == 0)
                  push_result(ST_NOTFOUND, 0, val, 0, 1'b1);
            end
         end
         CMD_FIND_ALL: begin
            if (model_fill == 0) begin
               push_result(ST_EMPTY, 0, val, 0, 1'b1);
            end else begin
               for (i = 0; i < model_fill; i++)
                  if (model_entries[i] == val) begin
                     push_result(ST_OK, i, val, 0, 1'b0);
                     hits++;
                  end
               push_result((hits != 0) ? ST_OK : ST_NOTFOUND, 0, val, hits, 1'b1);
            end
         end
         CMD_DUMP: begin
            if (model_fill == 0) begin
               push_result(ST_EMPTY, 0, val, 0, 1'b1);
            end else begin
               for (i = 0; i < model_fill; i++)
                  push_result(ST_OK, i, model_entries[i], 0, (i + 1 == model_fill));
            end
         end
         default: ;
      endcase
   endtask

   // Offers one command word, with a random gap in front, and predicts it on acceptance.
   // Valid is left high afterwards so that back-to-back words need no second assignment.
   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= cmd;
      req_ch.item_value    <= val;
      req_ch.item_position <= pos;
      do @(posedge clock); while (!req_ch.ready);
      predict_list_command(cmd, val, pos);
      commands_sent++;
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 30)
         return value_pool[$urandom_range(3)];
      if (r < 55 && model_fill > 0)
         return model_entries[$urandom_range(model_fill - 1)];
      return $urandom;
   endfunction

   task automatic send_random_command();
      int r;
      int ins_weight;
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      r = $urandom_range(99);
      // Lean toward removal once the list is nearly full so that it keeps moving.
      ins_weight = (model_fill >= 12) ? 20 : 40;
      if (r < ins_weight)
         cmd = CMD_INSERT;
      else if (r < ins_weight + 10)
         cmd = CMD_FIND_FIRST;
      else if (r < ins_weight + 18)
         cmd = CMD_FIND_ALL;
      else if (r < ins_weight + 30)
         cmd = CMD_READ;
      else if (r < ins_weight + 35)
         cmd = CMD_DUMP;
      else if (r < ins_weight + 39)
         cmd = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
      else
         cmd = CMD_REMOVE;
      if ($urandom_range(99) < 12)
         pos = POS_W'($urandom_range(31));
      else if (cmd == CMD_INSERT)
         pos = POS_W'($urandom_range(model_fill));
      else
         pos = (model_fill > 0) ? POS_W'($urandom_range(model_fill - 1)) : '0;
      send_command(cmd, pick_value(), pos);
   endtask

   task automatic test_empty_list();
      send_command(CMD_READ, 32'sd0, 5'd0);
      send_command(CMD_REMOVE, VAL_MAX, 5'd31);
      send_command(CMD_FIND_FIRST, VAL_MIN, 5'd0);
      send_command(CMD_FIND_ALL, 32'sd0, 5'd0);
      send_command(CMD_DUMP, -32'sd1, 5'd0);
      send_command(CMD_INSERT, 32'sd9, 5'd1);
      send_command(CMD_INSERT, 32'sd9, 5'd31);
      wait_for_results();
   endtask

   task automatic test_directed_ops();
      send_command(CMD_INSERT, VAL_MIN, 5'd0);
      send_command(CMD_INSERT, VAL_MAX, 5'd1);
      send_command(CMD_INSERT, -32'sd1, 5'd0);
      send_command(CMD_INSERT, 32'sd5, 5'd2);
      send_command(CMD_INSERT, VAL_MAX, 5'd4);
      send_command(CMD_FIND_FIRST, VAL_MAX, 5'd0);
      send_command(CMD_FIND_FIRST, 32'sd12345, 5'd0);
      send_command(CMD_FIND_ALL, VAL_MAX, 5'd0);
      send_command(CMD_FIND_ALL, 32'sd12345, 5'd0);
      send_command(CMD_READ, 32'sd0, 5'd0);
      send_command(CMD_READ, 32'sd0, 5'd5);
      send_command(CMD_READ, 32'sd0, 5'd31);
      send_command(CMD_REMOVE, 32'sd0, 5'd2);
      send_command(CMD_REMOVE, 32'sd0, 5'd4);
      send_command(CMD_DUMP, 32'sd0, 5'd0);
      send_command(CMD_UNUSED_6, VAL_MAX, 5'd31);
      send_command(CMD_UNUSED_7, VAL_MIN, 5'd0);
      send_command(CMD_READ, 32'sd0, 5'd3);
      wait_for_results();
   endtask

   // Fills the list with one repeated value so that find-all gives its longest run.
   task automatic test_capacity();
      while (model_fill > 0)
         send_command(CMD_REMOVE, pick_value(), 5'd0);
      while (model_fill < LIST_DEPTH)
         send_command(CMD_INSERT, VAL_TWIN, POS_W'($urandom_range(model_fill)));
      send_command(CMD_FIND_ALL, VAL_TWIN, 5'd0);
      send_command(CMD_INSERT, 32'sd1, 5'd3);
      send_command(CMD_INSERT, 32'sd1, 5'd16);
      send_command(CMD_READ, 32'sd0, 5'd15);
      send_command(CMD_READ, 32'sd0, 5'd16);
      send_command(CMD_REMOVE, 32'sd0, 5'd15);
      send_command(CMD_REMOVE, 32'sd0, 5'd0);
      send_command(CMD_INSERT, VAL_MAX, 5'd14);
      send_command(CMD_FIND_FIRST, VAL_MAX, 5'd0);
      send_command(CMD_DUMP, 32'sd0, 5'd0);
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while words keep coming, so the block backs up.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_start    = 1'b1;
      send_command(CMD_DUMP, 32'sd0, 5'd0);
      send_command(CMD_FIND_ALL, VAL_TWIN, 5'd0);
      send_command(CMD_INSERT, VAL_TWIN, 5'd0);
      send_command(CMD_DUMP, 32'sd0, 5'd0);
      send_command(CMD_READ, 32'sd0, 5'd1);
      send_command(CMD_REMOVE, 32'sd0, 5'd2);
      send_command(CMD_FIND_FIRST, VAL_TWIN, 5'd0);
      wait_for_results();
   endtask

   task automatic test_random_phase(input int count, input int idle_pct, input int stall);
      int k;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (k = 0; k < count; k++)
         send_random_command();
      wait_for_results();
      phases_run++;
   endtask

   task automatic check_result_word();
      list_result_type want;
      words_seen++;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("unexpected word: status %0d pos %0d value %0d",
                                   rsp_ch.status, rsp_ch.found_position,
                                   rsp_ch.entry_value));
         return;
      end
      want = expected_words.pop_front();
      if (rsp_ch.status !== want.status)
         report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                   words_seen, rsp_ch.status, want.status));
      if (rsp_ch.found_position !== want.found_position)
         report_mismatch($sformatf("word %0d found_position %0d, expected %0d",
                                   words_seen, rsp_ch.found_position, want.found_position));
      if (rsp_ch.entry_value !== want.entry_value)
         report_mismatch($sformatf("word %0d entry_value %0d, expected %0d",
                                   words_seen, rsp_ch.entry_value, want.entry_value));
      if (rsp_ch.match_count !== want.match_count)
         report_mismatch($sformatf("word %0d match_count %0d, expected %0d",
                                   words_seen, rsp_ch.match_count, want.match_count));
      if (rsp_ch.last_of_run !== want.last_of_run)
         report_mismatch($sformatf("word %0d last_of_run %0b, expected %0b",
                                   words_seen, rsp_ch.last_of_run, want.last_of_run));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         check_result_word();
   end

   initial begin
      rsp_ch.ready = 1'b0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
         $display("FAIL positional_list_table");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.cmd           = CMD_INSERT;
      req_ch.item_value    = '0;
      req_ch.item_position = '0;
      send_idle_pct        = 0;
      stall_pct            = 0;
      hold_start           = 1'b0;
      model_fill           = 0;
      errors               = 0;
      commands_sent        = 0;
      words_seen           = 0;
      phases_run           = 0;
      quiet_cycles         = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_directed_ops();
      test_capacity();
      test_backpressure();
      test_random_phase(22, 0, 0);
      test_random_phase(22, 52, 0);
      test_random_phase(22, 0, 52);
      test_random_phase(22, 13, 13);

      $display("Covered %0d command words and %0d result words, %0d random phases.",
               commands_sent, words_seen, phases_run);
      $display("Included empty, full and bad-position errors, 16-way find-all and a long stall.");
      if (errors == 0 && expected_words.size() == 0) begin
         $display("PASS positional_list_table");
      end else begin
         $display("%0d mismatches, %0d words still expected.", errors, expected_words.size());
         $display("FAIL positional_list_table");
      end
      $finish;
   end

endmodule
